>>> rtl/gna_pkg.sv
// Shared types, constants and helper functions for the gauge needle animator.
package gna_pkg;

	localparam int TIMER_W    = 16;
	localparam int INTERVAL_W = 16;
	localparam int STEP_W     = 7;
	localparam int VAL_W      = 7;
	localparam int TGT_W      = 8;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam int IN_W       = 24;
	localparam int OUT_W      = 24;

	localparam logic [VAL_W-1:0] FULL_SCALE = VAL_W'(100);
	localparam logic [VAL_W-1:0] CPU_RESET  = VAL_W'(50);
	localparam logic [VAL_W-1:0] STO_RESET  = VAL_W'(25);

	localparam logic [INTERVAL_W-1:0] EASE_INTERVAL_RST  = INTERVAL_W'(20);
	localparam logic [INTERVAL_W-1:0] SWEEP_INTERVAL_RST = INTERVAL_W'(15);
	localparam logic [STEP_W-1:0]     SWEEP_STEP_RST     = STEP_W'(2);

	typedef enum logic [2:0] {
		REG_EASE_INTERVAL  = 3'd0,
		REG_OUT_INTERVAL   = 3'd1,
		REG_BACK_INTERVAL  = 3'd2,
		REG_OUT_STEP       = 3'd3,
		REG_BACK_STEP      = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_OUT,
		MODE_BACK,
		MODE_EASE
	} gauge_mode_t;

	typedef struct packed {
		logic [INTERVAL_W-1:0] ease_interval;
		logic [INTERVAL_W-1:0] sweep_out_interval;
		logic [INTERVAL_W-1:0] sweep_back_interval;
		logic [STEP_W-1:0]     sweep_out_step;
		logic [STEP_W-1:0]     sweep_back_step;
	} gna_cfg_t;

	function automatic logic [VAL_W-1:0] clamp_pct(input logic [TGT_W-1:0] raw);
		logic [VAL_W-1:0] res;
		if (raw > TGT_W'(FULL_SCALE)) begin
			res = FULL_SCALE;
		end else begin
			res = raw[VAL_W-1:0];
		end
		return res;
	endfunction

	// Easing step chosen by distance to target
	function automatic logic [STEP_W-1:0] ease_step(input logic [VAL_W-1:0] diff);
		logic [STEP_W-1:0] res;
		if (diff >= VAL_W'(40)) begin
			res = STEP_W'(10);
		end else if (diff >= VAL_W'(20)) begin
			res = STEP_W'(6);
		end else if (diff >= VAL_W'(8)) begin
			res = STEP_W'(3);
		end else if (diff >= VAL_W'(3)) begin
			res = STEP_W'(2);
		end else begin
			res = STEP_W'(1);
		end
		return res;
	endfunction

	function automatic logic [TIMER_W-1:0] timer_inc(input logic [TIMER_W-1:0] t);
		logic [TIMER_W-1:0] res;
		if (&t) begin
			res = t;
		end else begin
			res = t + TIMER_W'(1);
		end
		return res;
	endfunction

endpackage

>>> rtl/gna_regs.sv
// Configuration register file behind the APB-style port.
module gna_regs
	import gna_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output gna_cfg_t          cfg
);

	gna_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ease_interval       <= EASE_INTERVAL_RST;
			cfg_q.sweep_out_interval  <= SWEEP_INTERVAL_RST;
			cfg_q.sweep_back_interval <= SWEEP_INTERVAL_RST;
			cfg_q.sweep_out_step      <= SWEEP_STEP_RST;
			cfg_q.sweep_back_step     <= SWEEP_STEP_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_EASE_INTERVAL: cfg_q.ease_interval       <= pwdata[INTERVAL_W-1:0];
				REG_OUT_INTERVAL:  cfg_q.sweep_out_interval  <= pwdata[INTERVAL_W-1:0];
				REG_BACK_INTERVAL: cfg_q.sweep_back_interval <= pwdata[INTERVAL_W-1:0];
				REG_OUT_STEP:      cfg_q.sweep_out_step      <= pwdata[STEP_W-1:0];
				REG_BACK_STEP:     cfg_q.sweep_back_step     <= pwdata[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_EASE_INTERVAL: prdata = DATA_W'(cfg_q.ease_interval);
			REG_OUT_INTERVAL:  prdata = DATA_W'(cfg_q.sweep_out_interval);
			REG_BACK_INTERVAL: prdata = DATA_W'(cfg_q.sweep_back_interval);
			REG_OUT_STEP:      prdata = DATA_W'(cfg_q.sweep_out_step);
			REG_BACK_STEP:     prdata = DATA_W'(cfg_q.sweep_back_step);
			default:           prdata = '0;
		endcase
	end

endmodule

>>> rtl/gna_gauge.sv
// Next-value logic for one gauge needle: sweep up, fixed return step or easing.
module gna_gauge
	import gna_pkg::*;
(
	input  gauge_mode_t       mode,
	input  logic [VAL_W-1:0]  cur,
	input  logic [VAL_W-1:0]  tgt,
	input  logic [STEP_W-1:0] out_step,
	input  logic [STEP_W-1:0] back_step,
	output logic [VAL_W-1:0]  nxt
);

	logic [VAL_W:0]    sum;
	logic [VAL_W-1:0]  diff;
	logic [STEP_W-1:0] step;
	logic [VAL_W-1:0]  toward;

	assign sum  = {1'b0, cur} + {1'b0, out_step};
	assign diff = (cur > tgt) ? (cur - tgt) : (tgt - cur);
	assign step = (mode == MODE_EASE) ? ease_step(diff) : back_step;

	always_comb begin
		if (cur == tgt) begin
			toward = cur;
		end else if (diff <= step) begin
			toward = tgt;
		end else if (cur < tgt) begin
			toward = cur + step;
		end else begin
			toward = cur - step;
		end
	end

	always_comb begin
		unique case (mode)
			MODE_OUT: begin
				nxt = (sum > (VAL_W + 1)'(FULL_SCALE)) ? FULL_SCALE : sum[VAL_W-1:0];
			end
			MODE_BACK, MODE_EASE: nxt = toward;
			default:              nxt = cur;
		endcase
	end

endmodule

>>> rtl/gauge_needle_animator.sv
// Top level of the gauge needle animator: tick stream in, gauge state out.
//
// Usage: each transaction on the s_t* channel is one millisecond tick carrying
// the enable level, a skip-sweep request and raw cpu/storage targets (clamped
// to 100 inside). Every tick yields exactly one result transaction on the m_t*
// channel with both shown values, the sweep/return phase flags and redraw.
// Configuration registers (intervals and sweep steps) sit on the APB port at
// byte addresses 0, 4, 8, 12 and 16; write them only while no tick is in flight.
// A tick passes through the input register and then the result register before
// it is presented on m_tvalid. Throughput: one tick per cycle unless m_tready
// stalls; state update for a tick is a single pass of compares and adds through
// the gauge logic between the two registers.
// Stall: while m_tready is low the result holds and one more tick can wait in
// the input register; s_tready drops only when both are full.
// Reset: values return to 50 and 25, sweep and skip state clear, timers
// restart at zero and the registers take their default values.
module gauge_needle_animator
	import gna_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// enable[0], skip_request[1], cpu_target[9:2], storage_target[17:10], zeros
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// cpu_shown[6:0], storage_shown[13:7], sweeping[14], returning[15], redraw[16]
	output logic [OUT_W-1:0]  m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	gna_cfg_t cfg;

	logic              vld_s1;
	logic              en_s1;
	logic              skip_s1;
	logic [TGT_W-1:0]  cpu_raw_s1;
	logic [TGT_W-1:0]  sto_raw_s1;
	logic              fire;

	logic [VAL_W-1:0]   cpu_q, sto_q;
	logic               en_q, on_q, back_q, skip_q;
	logic [TIMER_W-1:0] ease_el_q, sweep_el_q;

	logic              out_vld_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [VAL_W-1:0]   cpu_t, sto_t;
	logic [TIMER_W-1:0] ease_t, sweep_t;
	logic               rise, fall, skip_p;
	logic [VAL_W-1:0]   cpu_mid, sto_mid;
	logic               on_mid;
	logic [INTERVAL_W-1:0] sweep_iv;
	logic               sweep_go, ease_go;
	gauge_mode_t        mode;
	logic [VAL_W-1:0]   cpu_nx, sto_nx;
	logic               on_n, back_n, skip_n, redraw;
	logic [TIMER_W-1:0] ease_n, sweep_n;

	gna_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign fire     = vld_s1 & (~out_vld_q | m_tready);
	assign s_tready = ~vld_s1 | fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			en_s1      <= s_tdata[0];
			skip_s1    <= s_tdata[1];
			cpu_raw_s1 <= s_tdata[9:2];
			sto_raw_s1 <= s_tdata[17:10];
		end
	end

	assign cpu_t   = clamp_pct(cpu_raw_s1);
	assign sto_t   = clamp_pct(sto_raw_s1);
	assign ease_t  = timer_inc(ease_el_q);
	assign sweep_t = timer_inc(sweep_el_q);
	assign rise    = en_s1 & ~en_q;
	assign fall    = ~en_s1 & en_q;
	assign skip_p  = skip_q | skip_s1;

	always_comb begin
		cpu_mid = cpu_q;
		sto_mid = sto_q;
		on_mid  = on_q & ~fall;
		if (rise) begin
			if (skip_p) begin
				cpu_mid = cpu_t;
				sto_mid = sto_t;
				on_mid  = 1'b0;
			end else begin
				cpu_mid = '0;
				sto_mid = '0;
				on_mid  = 1'b1;
			end
		end
	end

	// Back flag after the edge step: clear on any enable change
	assign sweep_iv = (back_q & ~rise & ~fall) ? cfg.sweep_back_interval
	                                            : cfg.sweep_out_interval;
	assign sweep_go = en_s1 & on_mid & ((rise & ~skip_p) | (sweep_t >= sweep_iv));
	assign ease_go  = en_s1 & ~on_mid & (ease_t >= cfg.ease_interval);

	always_comb begin
		if (sweep_go) begin
			mode = (back_q & ~rise) ? MODE_BACK : MODE_OUT;
		end else if (ease_go) begin
			mode = MODE_EASE;
		end else begin
			mode = MODE_HOLD;
		end
	end

	gna_gauge u_cpu (
		.mode      (mode),
		.cur       (cpu_mid),
		.tgt       (cpu_t),
		.out_step  (cfg.sweep_out_step),
		.back_step (cfg.sweep_back_step),
		.nxt       (cpu_nx)
	);

	gna_gauge u_sto (
		.mode      (mode),
		.cur       (sto_mid),
		.tgt       (sto_t),
		.out_step  (cfg.sweep_out_step),
		.back_step (cfg.sweep_back_step),
		.nxt       (sto_nx)
	);

	always_comb begin
		on_n    = on_mid;
		back_n  = back_q & ~rise & ~fall;
		skip_n  = skip_p & ~rise;
		ease_n  = ease_go ? '0 : ease_t;
		sweep_n = sweep_go ? '0 : sweep_t;
		if (mode == MODE_OUT && cpu_nx == FULL_SCALE && sto_nx == FULL_SCALE) begin
			back_n = 1'b1;
		end
		if (mode == MODE_BACK && cpu_nx == cpu_t && sto_nx == sto_t) begin
			on_n   = 1'b0;
			back_n = 1'b0;
			ease_n = '0;
		end
	end

	assign redraw = en_s1 & (rise | (cpu_nx != cpu_q) | (sto_nx != sto_q) |
	                         (on_n != on_q) | (back_n != back_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_q      <= CPU_RESET;
			sto_q      <= STO_RESET;
			en_q       <= 1'b0;
			on_q       <= 1'b0;
			back_q     <= 1'b0;
			skip_q     <= 1'b0;
			ease_el_q  <= '0;
			sweep_el_q <= '0;
		end else if (fire) begin
			cpu_q      <= cpu_nx;
			sto_q      <= sto_nx;
			en_q       <= en_s1;
			on_q       <= on_n;
			back_q     <= back_n;
			skip_q     <= skip_n;
			ease_el_q  <= ease_n;
			sweep_el_q <= sweep_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {(OUT_W - 17)'(0), redraw, back_n, on_n, sto_nx, cpu_nx};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule
